>>> src/ttdd_pkg.sv
// ----------------------------------------------------------------------------
// ttdd_pkg
// Shared constants, types and the arctangent table for the tilt mixer.
// ----------------------------------------------------------------------------
package ttdd_pkg;

  localparam int CORDIC_STEPS = 15;
  localparam int CW           = 35;   // CORDIC x/y datapath width
  localparam int AW           = 17;   // CORDIC angle accumulator width
  localparam int CORD_LAT     = CORDIC_STEPS + 2;
  localparam int PIPE_LEN     = CORD_LAT + 4;

  localparam logic signed [15:0] HALF_PI_Q14 = 16'sd25736;
  localparam logic signed [17:0] ONE_Q14     = 18'sd16384;

  localparam logic [15:0] SPEED_GAIN_RST = 16'd4096;
  localparam logic [14:0] DEAD_ZONE_RST  = 15'd3277;
  localparam logic [14:0] TILT_LIMIT_RST = 15'd16384;

  typedef enum logic [1:0] {
    REG_SPEED_GAIN = 2'd0,
    REG_DEAD_ZONE  = 2'd1,
    REG_TILT_LIMIT = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  function automatic logic signed [AW-1:0] atan_q14(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0:       r = 17'sd12868;
      1:       r = 17'sd7596;
      2:       r = 17'sd4014;
      3:       r = 17'sd2037;
      4:       r = 17'sd1023;
      5:       r = 17'sd512;
      6:       r = 17'sd256;
      7:       r = 17'sd128;
      8:       r = 17'sd64;
      9:       r = 17'sd32;
      10:      r = 17'sd16;
      11:      r = 17'sd8;
      12:      r = 17'sd4;
      13:      r = 17'sd2;
      14:      r = 17'sd1;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/ttdd_if.sv
// ----------------------------------------------------------------------------
// ttdd channel interfaces
// Sample, result and configuration-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface ttdd_sample_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface ttdd_result_if;
  logic             valid;
  logic             ready;
  logic signed [7:0] motor_left;
  logic signed [7:0] motor_right;
  modport source (output valid, motor_left, motor_right, input ready);
  modport sink   (input valid, motor_left, motor_right, output ready);
endinterface

interface ttdd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/ttdd_cordic.sv
// ----------------------------------------------------------------------------
// ttdd_cordic
// Pipelined vectoring CORDIC arctangent of num/den in Q2.14, one step a stage.
// ----------------------------------------------------------------------------
module ttdd_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] num,
  input  logic signed [15:0] den,
  output logic signed [15:0] tilt
);
  import ttdd_pkg::*;

  logic signed [CW-1:0] cx   [0:CORDIC_STEPS];
  logic signed [CW-1:0] cy   [0:CORDIC_STEPS];
  logic signed [AW-1:0] ang  [0:CORDIC_STEPS];
  logic                 spec [0:CORDIC_STEPS];
  logic signed [15:0]   specv[0:CORDIC_STEPS];
  logic                 neg  [0:CORDIC_STEPS];

  logic [16:0] nabs;
  logic [16:0] dabs;
  logic signed [16:0] den_x;

  assign den_x = {den[15], den};
  assign nabs  = num[16] ? 17'(-num) : 17'(num);
  assign dabs  = den_x[16] ? 17'(-den_x) : 17'(den_x);

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]   <= $signed({{(CW-33){1'b0}}, dabs, 16'd0});
      cy[0]   <= $signed({{(CW-33){1'b0}}, nabs, 16'd0});
      ang[0]  <= '0;
      neg[0]  <= num[16] ^ den[15];
      spec[0] <= (num == 17'sd0) || (den == 16'sd0);
      if (num == 17'sd0) begin
        specv[0] <= 16'sd0;
      end else if (num[16]) begin
        specv[0] <= -HALF_PI_Q14;
      end else begin
        specv[0] <= HALF_PI_Q14;
      end
    end
  end

  for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[k-1] > 0) begin
          cx[k]  <= cx[k-1] + (cy[k-1] >>> (k-1));
          cy[k]  <= cy[k-1] - (cx[k-1] >>> (k-1));
          ang[k] <= ang[k-1] + atan_q14(k-1);
        end else begin
          cx[k]  <= cx[k-1] - (cy[k-1] >>> (k-1));
          cy[k]  <= cy[k-1] + (cx[k-1] >>> (k-1));
          ang[k] <= ang[k-1] - atan_q14(k-1);
        end
        spec[k]  <= spec[k-1];
        specv[k] <= specv[k-1];
        neg[k]   <= neg[k-1];
      end
    end
  end

  logic signed [AW-1:0] afin;
  logic signed [15:0]   mag;

  assign afin = ang[CORDIC_STEPS];

  always_comb begin
    if (afin < 0) begin
      mag = 16'sd0;
    end else if (afin > AW'(HALF_PI_Q14)) begin
      mag = HALF_PI_Q14;
    end else begin
      mag = afin[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (spec[CORDIC_STEPS]) begin
        tilt <= specv[CORDIC_STEPS];
      end else if (neg[CORDIC_STEPS]) begin
        tilt <= -mag;
      end else begin
        tilt <= mag;
      end
    end
  end

endmodule

>>> src/tilt_to_differential_drive_core.sv
// ----------------------------------------------------------------------------
// tilt_to_differential_drive_core
// Accelerometer tilt to left/right motor percent commands.
// ----------------------------------------------------------------------------
// Usage:
//   sample: one transfer per accelerometer reading (accel_x, accel_y, accel_z).
//   result: one transfer per sample, motor_left / motor_right in percent.
//   cfg:    register writes (0 speed_gain, 1 dead_zone, 2 tilt_limit); always
//           ready; write only while no sample is in flight.
// Throughput is one sample per cycle while result is not stalled. Path from
// sample to result: two 15-stage CORDIC lanes plus prep and output stages,
// then shaping, gain multiply, mix multiply and percent scaling.
// When result is stalled the whole pipeline holds and sample.ready drops;
// nothing is dropped or repeated. Reset clears all stage valid bits and
// loads the register reset values (gain 1.0, dead zone 0.2, limit 1 rad).
// ----------------------------------------------------------------------------
module tilt_to_differential_drive_core (
  input  logic clk,
  input  logic rst,
  ttdd_sample_if.sink   sample,
  ttdd_result_if.source result,
  ttdd_cfg_if.sink      cfg
);
  import ttdd_pkg::*;

  logic [15:0] speed_gain;
  logic [14:0] dead_zone;
  logic [14:0] tilt_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain <= SPEED_GAIN_RST;
      dead_zone  <= DEAD_ZONE_RST;
      tilt_limit <= TILT_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_SPEED_GAIN: speed_gain <= cfg.data;
        REG_DEAD_ZONE:  dead_zone  <= cfg.data[14:0];
        REG_TILT_LIMIT: tilt_limit <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic vld [0:PIPE_LEN-1];

  assign en           = !vld[PIPE_LEN-1] || result.ready;
  assign sample.ready = en;
  assign result.valid = vld[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LEN; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= sample.valid;
      for (int i = 1; i < PIPE_LEN; i++) vld[i] <= vld[i-1];
    end
  end

  logic signed [16:0] num_f;
  logic signed [16:0] num_s;
  logic signed [15:0] f_t;
  logic signed [15:0] s_t;

  assign num_f = -$signed({sample.accel_x[15], sample.accel_x});
  assign num_s = -$signed({sample.accel_y[15], sample.accel_y});

  ttdd_cordic u_fwd (.clk, .en, .num(num_f), .den(sample.accel_z), .tilt(f_t));
  ttdd_cordic u_side (.clk, .en, .num(num_s), .den(sample.accel_z), .tilt(s_t));

  function automatic logic signed [15:0] shape(input logic signed [15:0] t,
                                               input logic [14:0] lim,
                                               input logic [14:0] dz);
    logic signed [16:0] tx;
    logic signed [16:0] l;
    logic signed [16:0] d;
    tx = {t[15], t};
    l  = $signed({2'b00, lim});
    d  = $signed({2'b00, dz});
    if (tx > l) begin
      tx = l;
    end else if (tx < -l) begin
      tx = -l;
    end
    if (tx > -d && tx < d) begin
      tx = 17'sd0;
    end
    return tx[15:0];
  endfunction

  // shaping stage
  logic signed [15:0] f_sh;
  logic signed [15:0] s_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      f_sh <= shape(f_t, tilt_limit, dead_zone);
      s_sh <= shape(s_t, tilt_limit, dead_zone);
    end
  end

  // gain stage; side-only case prescaled by 2^13 to share the 2^40 scale
  logic signed [32:0] gmul;
  logic signed [17:0] dl;
  logic signed [17:0] dr;
  logic signed [16:0] g_s;

  assign g_s = $signed({1'b0, speed_gain});

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_sh != 16'sd0 && f_sh == 16'sd0) begin
        gmul <= $signed({4'b0000, speed_gain, 13'd0});
      end else begin
        gmul <= g_s * f_sh;
      end
      dl <= ONE_Q14 - {{2{s_sh[15]}}, s_sh};
      dr <= ONE_Q14 + {{2{s_sh[15]}}, s_sh};
    end
  end

  // mix stage
  logic signed [50:0] pl;
  logic signed [50:0] pr;

  always_ff @(posedge clk) begin
    if (en) begin
      pl <= gmul * dl;
      pr <= gmul * dr;
    end
  end

  function automatic logic signed [7:0] to_pct(input logic signed [50:0] p);
    logic [50:0] m;
    logic [57:0] prod;
    logic [17:0] q;
    logic [7:0]  qs;
    m    = p[50] ? 51'(-p) : 51'(p);
    prod = {7'd0, m} * 58'd100;
    q    = prod[57:40];
    qs   = (q > 18'd100) ? 8'd100 : q[7:0];
    return p[50] ? $signed(-qs) : $signed(qs);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      result.motor_left  <= to_pct(pl);
      result.motor_right <= to_pct(pr);
    end
  end

  a_tilt_range: assert property (@(posedge clk) disable iff (rst)
    vld[CORD_LAT-1] |->
    (f_t <= HALF_PI_Q14 && f_t >= -HALF_PI_Q14 &&
     s_t <= HALF_PI_Q14 && s_t >= -HALF_PI_Q14))
    else $error("cordic tilt out of range");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.motor_left <= 8'sd100 && result.motor_left >= -8'sd100 &&
                      result.motor_right <= 8'sd100 && result.motor_right >= -8'sd100))
    else $error("motor command out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!en) |=> (vld[PIPE_LEN-1] == $past(vld[PIPE_LEN-1]) && vld[0] == $past(vld[0])))
    else $error("pipeline moved during stall");

endmodule

>>> test/ttdd_checker.sv
// ----------------------------------------------------------------------------
// ttdd_checker
// Watches the cfg, sample and result channels of the tilt mixer, keeps its
// own register copy, predicts motor commands per sample transfer and
// compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module ttdd_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic smp_valid,
  input  logic smp_ready,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  input  logic res_valid,
  input  logic res_ready,
  input  logic signed [7:0] left,
  input  logic signed [7:0] right,
  output int   errors,
  output int   pending
);
  import ttdd_pkg::*;

  localparam longint ANGLE_LUT [15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128,
                                         64, 32, 16, 8, 4, 2, 1};

  typedef struct packed {
    logic signed [7:0] left;
    logic signed [7:0] right;
  } motor_cmd_t;

  motor_cmd_t cmd_q[$];
  longint gain, dz, lim;

  function automatic longint tilt_angle(longint num, longint den);
    longint cx, cy, dx, dy, ang;
    bit neg;
    ang = 0;
    if (num == 0) return 0;
    if (den == 0) return num > 0 ? 25736 : -25736;
    neg = (num < 0) != (den < 0);
    cx = (den < 0 ? -den : den) <<< 16;
    cy = (num < 0 ? -num : num) <<< 16;
    for (int i = 0; i < 15; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; ang += ANGLE_LUT[i];
      end else begin
        cx -= dx; cy += dy; ang -= ANGLE_LUT[i];
      end
    end
    if (ang < 0) ang = 0;
    if (ang > 25736) ang = 25736;
    return neg ? -ang : ang;
  endfunction

  function automatic longint shaped(longint t);
    if (t > lim) t = lim;
    else if (t < -lim) t = -lim;
    if (t > -dz && t < dz) t = 0;
    return t;
  endfunction

  function automatic logic signed [7:0] percent(longint p, int sh);
    longint m, q;
    m = p < 0 ? -p : p;
    q = (m * 100) >>> sh;
    if (q > 100) q = 100;
    return 8'(p < 0 ? -q : q);
  endfunction

  function automatic motor_cmd_t mix(longint x, longint y, longint z);
    longint f, s;
    motor_cmd_t c;
    f = shaped(tilt_angle(-x, z));
    s = shaped(tilt_angle(-y, z));
    if (s != 0 && f == 0) begin
      c.left  = percent(gain * (16384 - s), 27);
      c.right = percent(gain * (16384 + s), 27);
    end else begin
      c.left  = percent(gain * f * (16384 - s), 40);
      c.right = percent(gain * f * (16384 + s), 40);
    end
    return c;
  endfunction

  assign pending = cmd_q.size();

  always @(posedge clk) begin
    motor_cmd_t e;
    int n;
    n = 0;
    if (rst) begin
      gain <= longint'(SPEED_GAIN_RST);
      dz <= longint'(DEAD_ZONE_RST);
      lim <= longint'(TILT_LIMIT_RST);
      cmd_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_SPEED_GAIN: gain <= longint'(cfg_data);
          REG_DEAD_ZONE:  dz <= longint'(cfg_data[14:0]);
          REG_TILT_LIMIT: lim <= longint'(cfg_data[14:0]);
          default: ;
        endcase
      end
      if (smp_valid && smp_ready) cmd_q.push_back(mix(ax, ay, az));
      if (res_valid && res_ready) begin
        if (cmd_q.size() == 0) begin
          $error("unexpected result transfer");
          n++;
        end else begin
          e = cmd_q.pop_front();
          if (e.left !== left) begin
            $error("motor_left expected %0d actual %0d", e.left, left);
            n++;
          end
          if (e.right !== right) begin
            $error("motor_right expected %0d actual %0d", e.right, right);
            n++;
          end
        end
      end
      errors <= errors + n;
    end
  end

endmodule

>>> test/tilt_to_differential_drive_core_test.sv
// ----------------------------------------------------------------------------
// tilt_to_differential_drive_core_test
// Drives directed and random accelerometer samples through the mixer over
// several register settings, with random idling on both sides; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tilt_to_differential_drive_core_test;
  import ttdd_pkg::*;

  logic clk;
  logic rst;
  int   errors, pending;
  int   src_idle, snk_idle;
  int   quiet;

  ttdd_sample_if sample();
  ttdd_result_if result();
  ttdd_cfg_if    cfg();

  tilt_to_differential_drive_core uut (
    .clk(clk), .rst(rst), .sample(sample), .result(result), .cfg(cfg)
  );

  ttdd_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_index(cfg.index),
    .cfg_data(cfg.data),
    .smp_valid(sample.valid), .smp_ready(sample.ready),
    .ax(sample.accel_x), .ay(sample.accel_y), .az(sample.accel_z),
    .res_valid(result.valid), .res_ready(result.ready),
    .left(result.motor_left), .right(result.motor_right),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) result.ready <= 0;
    else result.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready)
        || (cfg.valid && cfg.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("tilt_to_differential_drive_core test failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
  endtask

  task automatic send(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < src_idle) begin
      sample.valid <= 0;
      @(posedge clk);
    end
    sample.valid   <= 1;
    sample.accel_x <= x;
    sample.accel_y <= y;
    sample.accel_z <= z;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
  endtask

  task automatic drain();
    sample.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_axis();
    case ($urandom_range(5))
      0: return 16'($urandom_range(40)) - 16'd20;
      1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic directed();
    logic [15:0] v [8] = '{16'h8000, 16'h7FFF, 0, 1, 16'hFFFF, 16'd1000, 16'hFC18, 16'd16384};
    send(0, 0, 0);
    send(16'd500, 0, 0);
    send(16'hFE0C, 16'h0100, 0);
    send(0, 16'hFF00, 0);
    send(0, 0, 16'd16384);
    send(0, 16'd3000, 16'd16384);
    send(16'd3000, 16'hF448, 16'd16384);
    for (int i = 0; i < 8; i++) send(v[i], v[7 - i], v[(i + 3) % 8]);
    send(16'h8000, 16'h8000, 16'h8000);
    send(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send(16'h8000, 16'h7FFF, 16'h0001);
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send(rnd_axis(), rnd_axis(), rnd_axis());
  endtask

  initial begin
    rst = 1;
    src_idle = 25;
    snk_idle = 51;
    sample.valid = 0;
    sample.accel_x = 0;
    sample.accel_y = 0;
    sample.accel_z = 0;
    cfg.valid = 0;
    cfg.index = 0;
    cfg.data = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    directed();
    random_run(150);
    drain();

    write_reg(REG_SPEED_GAIN, 16'hFFFF);
    write_reg(REG_DEAD_ZONE, 16'd0);
    write_reg(REG_TILT_LIMIT, 16'd25736);
    write_reg(REG_UNUSED, 16'h1234);
    src_idle = 51;
    snk_idle = 25;
    directed();
    random_run(200);
    drain();

    write_reg(REG_SPEED_GAIN, 16'd0);
    write_reg(REG_DEAD_ZONE, 16'hC000);
    write_reg(REG_TILT_LIMIT, 16'hFFFF);
    random_run(100);
    drain();

    write_reg(REG_SPEED_GAIN, 16'd2048);
    write_reg(REG_DEAD_ZONE, 16'd16384);
    write_reg(REG_TILT_LIMIT, 16'd100);
    random_run(100);
    drain();

    src_idle = 0;
    snk_idle = 0;
    write_reg(REG_SPEED_GAIN, 16'd20000);
    write_reg(REG_DEAD_ZONE, 16'd1000);
    write_reg(REG_TILT_LIMIT, 16'd20000);
    random_run(200);
    drain();

    write_reg(REG_SPEED_GAIN, 16'($urandom));
    write_reg(REG_DEAD_ZONE, 16'($urandom_range(4000)));
    write_reg(REG_TILT_LIMIT, 16'($urandom_range(25736)));
    random_run(264);
    drain();

    if (errors == 0) $display("tilt_to_differential_drive_core test passed");
    else $display("tilt_to_differential_drive_core test failed");
    $finish;
  end

endmodule
